/* sv/rig_pkg.sv */
`timescale 1ns / 1ps

package rig_pkg;

  localparam int BASE_W = 10;

  localparam logic [BASE_W-1:0] MIN_BASE = 10'd2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_MULM = 6'b000100,
    S_MULD = 6'b001000,
    S_FDIV = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

endpackage

/* sv/radical_inverse_generator.sv */
`timescale 1ns / 1ps

// Each digit is a bit-serial division over L dividend bits, where L is INDEX_BITS for the
// first digit and the bit length of the remaining quotient for each later one, followed by
// the multiply states S_MULM and S_MULD; a long division then forms the fraction bits, and
// an index of 0 or a base below 2 goes straight to that final division.
// Throughput: one item at a time; the single shared subtractor does every division step.
// Reset clears the sequencer and the output valid flag; no storage needs clearing.
module radical_inverse_generator #(
  parameter int INDEX_BITS    = 31,
  parameter int FRACTION_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [INDEX_BITS-1:0]         index,
  input  logic [rig_pkg::BASE_W-1:0]    base,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [FRACTION_BITS-1:0]      fraction
);

  localparam int BW    = rig_pkg::BASE_W;
  localparam int WIDE  = INDEX_BITS + BW;
  localparam int SUB_W = WIDE + 1;
  localparam int MAXC  = (INDEX_BITS > FRACTION_BITS) ? INDEX_BITS : FRACTION_BITS;
  localparam int CNT_W = $clog2(MAXC + 1);
  localparam int IDX_W = $clog2(INDEX_BITS);

  rig_pkg::state_t state;

  logic [INDEX_BITS-1:0]    work;
  logic [INDEX_BITS-1:0]    q;
  logic [BW-1:0]            r;
  logic [BW-1:0]            b_reg;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         qlen;
  logic [WIDE-1:0]          mirrored;
  logic [WIDE-1:0]          denom;
  logic [WIDE-1:0]          rem;
  logic [FRACTION_BITS-1:0] quot;

  logic [CNT_W-1:0] cnt_m1;
  logic             cur_bit;
  logic [BW:0]      r_sh;
  logic [SUB_W-1:0] sub_a;
  logic [SUB_W-1:0] sub_b;
  logic             sub_ge;
  logic [SUB_W-1:0] sub_diff;
  logic [WIDE-1:0]  mul_a;
  logic [BW-1:0]    mul_c;
  logic [WIDE-1:0]  mul_y;

  assign in_ready = (state == rig_pkg::S_IDLE);

  assign cnt_m1  = cnt - CNT_W'(1);
  assign cur_bit = work[cnt_m1[IDX_W-1:0]];
  assign r_sh    = {r, cur_bit};

  // The subtractor is shared by the digit division and the final long division.
  always_comb begin
    if (state == rig_pkg::S_FDIV) begin
      sub_a = {rem, 1'b0};
      sub_b = {1'b0, denom};
    end else begin
      sub_a = {{(SUB_W-BW-1){1'b0}}, r_sh};
      sub_b = {{(SUB_W-BW){1'b0}}, b_reg};
    end
  end

  rig_sub #(.W(SUB_W)) u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .ge   (sub_ge),
    .diff (sub_diff)
  );

  always_comb begin
    if (state == rig_pkg::S_MULM) begin
      mul_a = mirrored;
      mul_c = r;
    end else begin
      mul_a = denom;
      mul_c = '0;
    end
  end

  rig_mul #(.W(WIDE)) u_mul (
    .a (mul_a),
    .m (b_reg),
    .c (mul_c),
    .y (mul_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rig_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != rig_pkg::S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        rig_pkg::S_IDLE: begin
          if (in_valid) begin
            b_reg    <= base;
            work     <= index;
            q        <= '0;
            r        <= '0;
            qlen     <= '0;
            mirrored <= '0;
            denom    <= WIDE'(1);
            rem      <= '0;
            if (base < rig_pkg::MIN_BASE || index == '0) begin
              cnt   <= CNT_W'(FRACTION_BITS);
              state <= rig_pkg::S_FDIV;
            end else begin
              cnt   <= CNT_W'(INDEX_BITS);
              state <= rig_pkg::S_DIV;
            end
          end
        end
        rig_pkg::S_DIV: begin
          if (sub_ge) begin
            r <= sub_diff[BW-1:0];
          end else begin
            r <= r_sh[BW-1:0];
          end
          q <= {q[INDEX_BITS-2:0], sub_ge};
          if (sub_ge && qlen == '0) begin
            qlen <= cnt;
          end
          cnt <= cnt_m1;
          if (cnt == CNT_W'(1)) begin
            state <= rig_pkg::S_MULM;
          end
        end
        rig_pkg::S_MULM: begin
          mirrored <= mul_y;
          state    <= rig_pkg::S_MULD;
        end
        rig_pkg::S_MULD: begin
          denom <= mul_y;
          work  <= q;
          q     <= '0;
          r     <= '0;
          qlen  <= '0;
          if (q == '0) begin
            rem   <= mirrored;
            cnt   <= CNT_W'(FRACTION_BITS);
            state <= rig_pkg::S_FDIV;
          end else begin
            cnt   <= qlen;
            state <= rig_pkg::S_DIV;
          end
        end
        rig_pkg::S_FDIV: begin
          if (sub_ge) begin
            rem <= sub_diff[WIDE-1:0];
          end else begin
            rem <= sub_a[WIDE-1:0];
          end
          quot <= {quot[FRACTION_BITS-2:0], sub_ge};
          cnt  <= cnt_m1;
          if (cnt == CNT_W'(1)) begin
            state <= rig_pkg::S_DONE;
          end
        end
        rig_pkg::S_DONE: begin
          if (!out_valid || out_ready) begin
            fraction  <= quot;
            out_valid <= 1'b1;
            state     <= rig_pkg::S_IDLE;
          end
        end
        default: begin
          state <= rig_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/rig_sub.sv */
`timescale 1ns / 1ps

module rig_sub #(
  parameter int W = 43
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         ge,
  output logic [W-1:0] diff
);

  logic [W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign ge   = ~full[W];
  assign diff = full[W-1:0];

endmodule

/* sv/rig_mul.sv */
`timescale 1ns / 1ps

module rig_mul #(
  parameter int W = 42
) (
  input  logic [W-1:0]                 a,
  input  logic [rig_pkg::BASE_W-1:0]   m,
  input  logic [rig_pkg::BASE_W-1:0]   c,
  output logic [W-1:0]                 y
);

  logic [W+rig_pkg::BASE_W-1:0] full;

  assign full = ({{rig_pkg::BASE_W{1'b0}}, a} * {{W{1'b0}}, m})
              + {{W{1'b0}}, c};
  assign y    = full[W-1:0];

endmodule
